// ===== sv/lpg_pkg.sv =====
// lpg_pkg: shared types and constants of the line pixel generator
// depends on nothing; used by the interfaces and every module
package lpg_pkg;

  localparam int CoordW  = 6;
  localparam int PaintW  = 32;
  localparam int ErrW    = CoordW + 3;
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam int QCntW   = 2;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [PaintW-1:0] paint_t;

  // classified line command handed from front to back
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t major;
    coord_t minor;
    logic   x_major;
    logic   x_neg;
    logic   y_neg;
    paint_t paint;
  } lpg_line_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } lpg_q_status_t;

endpackage

// ===== sv/lpg_if.sv =====
// lpg_cmd_if and lpg_pix_if: valid/ready channels of line requests and pixel writes
// depends on lpg_pkg
interface lpg_cmd_if;
  import lpg_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  paint_t paint_value;
  modport source (output valid, start_x, start_y, end_x, end_y, paint_value, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, paint_value, output ready);
endinterface

interface lpg_pix_if;
  import lpg_pkg::*;
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  paint_t pixel_paint;
  logic   last_pixel;
  modport source (output valid, pixel_x, pixel_y, pixel_paint, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_paint, last_pixel, output ready);
endinterface

// ===== sv/lpg_front.sv =====
// lpg_front: accepts line requests and classifies them (deltas, major axis, directions)
// depends on lpg_pkg and lpg_cmd_if
module lpg_front #(
  parameter int COORD_BITS = 6
) (
  lpg_cmd_if.sink               in_cmd,
  input  lpg_pkg::lpg_q_status_t q_status,
  output logic                  push,
  output lpg_pkg::lpg_line_t    push_line
);
  import lpg_pkg::*;

  localparam coord_t CoordMask = coord_t'((1 << COORD_BITS) - 1);

  coord_t             ax, ay, bx, by;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]    adx_w, ady_w;
  coord_t             adx, ady;
  logic               x_major;

  always_comb begin
    ax = in_cmd.start_x & CoordMask;
    ay = in_cmd.start_y & CoordMask;
    bx = in_cmd.end_x & CoordMask;
    by = in_cmd.end_y & CoordMask;
    dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
    dy = $signed({1'b0, by}) - $signed({1'b0, ay});
    adx_w = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
    ady_w = dy[CoordW] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);
    adx = adx_w[CoordW-1:0];
    ady = ady_w[CoordW-1:0];
    x_major = (adx >= ady);

    push_line.x0      = ax;
    push_line.y0      = ay;
    push_line.major   = x_major ? adx : ady;
    push_line.minor   = x_major ? ady : adx;
    push_line.x_major = x_major;
    push_line.x_neg   = dx[CoordW];
    push_line.y_neg   = dy[CoordW];
    push_line.paint   = in_cmd.paint_value;
  end

  assign in_cmd.ready = !q_status.full;
  assign push         = in_cmd.valid && !q_status.full;

endmodule

// ===== sv/lpg_queue.sv =====
// lpg_queue: two-entry queue of classified line requests between front and back
// depends on lpg_pkg
module lpg_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lpg_pkg::lpg_line_t     push_line,
  input  logic                   pop,
  output lpg_pkg::lpg_line_t     pop_line,
  output lpg_pkg::lpg_q_status_t status
);
  import lpg_pkg::*;

  lpg_line_t         entry_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    status.full  = (cnt_r == QCntW'(QDepth));
    status.empty = (cnt_r == '0);
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    wr_ptr_nxt   = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt      = cnt_r + QCntW'(do_push) - QCntW'(do_pop);
  end

  assign pop_line = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_line;
    end
  end

endmodule

// ===== sv/lpg_back.sv =====
// lpg_back: Bresenham stepper, one pixel per cycle unless the output stalls, into a registered output
// depends on lpg_pkg and lpg_pix_if
module lpg_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpg_pkg::lpg_q_status_t q_status,
  input  lpg_pkg::lpg_line_t     pop_line,
  output logic                   pop,
  lpg_pix_if.source              out_pix
);
  import lpg_pkg::*;

  logic                   active_r, active_nxt;
  coord_t                 x_r, y_r, cnt_r;
  coord_t                 major_r, minor_r;
  logic                   x_major_r, x_neg_r, y_neg_r;
  paint_t                 paint_r;
  logic signed [ErrW-1:0] err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  coord_t                 out_x_r, out_y_r;
  paint_t                 out_paint_r;
  logic                   out_last_r;
  logic                   emit, last, err_pos, step_x, step_y;
  coord_t                 x_nxt, y_nxt;

  always_comb begin
    pop     = !active_r && !q_status.empty;
    emit    = active_r && (!out_valid_r || out_pix.ready);
    last    = (cnt_r == '0);
    err_pos = !err_r[ErrW-1] && (err_r != '0);
    step_x  = x_major_r || err_pos;
    step_y  = !x_major_r || err_pos;
    x_nxt   = step_x ? (x_neg_r ? x_r - 1'b1 : x_r + 1'b1) : x_r;
    y_nxt   = step_y ? (y_neg_r ? y_r - 1'b1 : y_r + 1'b1) : y_r;
    err_nxt = err_r + $signed({2'b00, minor_r, 1'b0})
            - (err_pos ? $signed({2'b00, major_r, 1'b0}) : $signed(ErrW'(0)));
    active_nxt = pop ? 1'b1 : (emit && last) ? 1'b0 : active_r;
    out_valid_nxt = emit ? 1'b1 : (out_pix.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r       <= pop_line.x0;
      y_r       <= pop_line.y0;
      cnt_r     <= pop_line.major;
      major_r   <= pop_line.major;
      minor_r   <= pop_line.minor;
      x_major_r <= pop_line.x_major;
      x_neg_r   <= pop_line.x_neg;
      y_neg_r   <= pop_line.y_neg;
      paint_r   <= pop_line.paint;
      err_r     <= $signed({2'b00, pop_line.minor, 1'b0})
                 - $signed({3'b000, pop_line.major});
    end else if (emit) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      cnt_r <= cnt_r - 1'b1;
      err_r <= err_nxt;
    end
    if (emit) begin
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_paint_r <= paint_r;
      out_last_r  <= last;
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.pixel_x     = out_x_r;
  assign out_pix.pixel_y     = out_y_r;
  assign out_pix.pixel_paint = out_paint_r;
  assign out_pix.last_pixel  = out_last_r;

endmodule

// ===== sv/line_pixel_generator_top.sv =====
// line_pixel_generator_top: Bresenham line generator, line requests in, pixel writes out
// depends on lpg_pkg, lpg_if, lpg_front, lpg_queue and lpg_back
//
// A line request with endpoints (start_x,start_y), (end_x,end_y) and a paint
// value yields max(|dx|,|dy|)+1 pixel writes, from the first endpoint to the
// second, with last_pixel set on the second endpoint. Only the low COORD_BITS
// bits of each coordinate are used. The stepper in the back end makes one pixel
// per cycle while the pixel output is not stalled, and loads each request from
// the two-entry request queue once the previous line is done; up to two
// requests are accepted ahead while a line is being drawn.
module line_pixel_generator_top #(
  parameter int COORD_BITS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  lpg_cmd_if.sink   in_cmd,
  lpg_pix_if.source out_pix
);
  import lpg_pkg::*;

  lpg_q_status_t q_status;
  lpg_line_t     push_line, pop_line;
  logic          push, pop;

  lpg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_cmd    (in_cmd),
    .q_status  (q_status),
    .push      (push),
    .push_line (push_line)
  );

  lpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_line (push_line),
    .pop       (pop),
    .pop_line  (pop_line),
    .status    (q_status)
  );

  lpg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_line (pop_line),
    .pop      (pop),
    .out_pix  (out_pix)
  );

endmodule
